// File: src/rmsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmsn_pkg;
   localparam int RowLen = 64;
   localparam int IdxW = (RowLen > 1) ? $clog2(RowLen) : 1;
   localparam int ShiftLen = $clog2(RowLen);
   localparam logic [15:0] EpsReset = 16'd17;

   typedef enum logic [2:0] {
      ST_FILL, ST_DIV, ST_ROOT, ST_DOT, ST_EMIT
   } state_type;
endpackage
`default_nettype wire

// File: src/rmsn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rmsn_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/rmsn_root.sv
`timescale 1ns / 1ps
`default_nettype none
// iterative unit: 61-bit restoring divide 2^60/m, then 31-step root search
module rmsn_root (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire [47:0]  m_val,
   output logic        done,
   output logic [30:0] inv_q
);
   import rmsn_pkg::*;

   logic [1:0]  ph_ff, ph_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] den_ff, den_in;
   logic [48:0] rem_ff, rem_in;
   logic [60:0] quo_ff, quo_in;
   logic [30:0] r_ff, r_in;
   logic [30:0] cand;
   logic [61:0] sq;
   logic [48:0] sh;
   logic        done_in, done_ff;

   // squaring a 31-bit candidate per step; one multiplier
   assign cand = r_ff | (31'd1 << cnt_ff[4:0]);
   assign sq   = {31'd0, cand} * {31'd0, cand};
   assign sh   = {rem_ff[47:0], quo_ff[60]};

   always_comb begin
      ph_in = ph_ff; cnt_in = cnt_ff; den_in = den_ff; rem_in = rem_ff;
      quo_in = quo_ff; r_in = r_ff; done_in = 1'b0;
      case (ph_ff)
         2'd0: begin
            if (start) begin
               den_in = (m_val == 48'd0) ? 48'd1 : m_val;
               rem_in = '0;
               quo_in = 61'd1 << 60;
               cnt_in = 6'd60;
               ph_in  = 2'd1;
            end
         end
         2'd1: begin
            if (sh >= {1'b0, den_ff}) begin
               rem_in = sh - {1'b0, den_ff};
               quo_in = {quo_ff[59:0], 1'b1};
            end else begin
               rem_in = sh;
               quo_in = {quo_ff[59:0], 1'b0};
            end
            if (cnt_ff == 6'd0) begin
               ph_in = 2'd2; cnt_in = 6'd30; r_in = '0;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         2'd2: begin
            if (sq <= {1'b0, quo_ff}) r_in = cand;
            if (cnt_ff == 6'd0) begin
               ph_in = 2'd0; done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         default: ph_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= 2'd0; done_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; done_ff <= done_in;
      end
      cnt_ff <= cnt_in; den_ff <= den_in; rem_ff <= rem_in;
      quo_ff <= quo_in; r_ff <= r_in;
   end

   assign done  = done_ff;
   assign inv_q = r_ff;
endmodule
`default_nettype wire

// File: src/rms_norm_forward_backward.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  fields (tdata low bit up)
// req      in   tuser: mode; tdata: x_value, grad_value, acc_value
// rsp      out  tdata: out_value, elem_index; tlast: row_last; tuser: saturated
// csr      in   epsilon_ms
// elements enter one per cycle into three 64x16 rams; after the last one
// a divider/root unit computes the inverse root, then the row is read back and
// emitted through a pipeline at up to one result per cycle.
// reset clears control and sets epsilon_ms to 17; rams need no clearing.
// rsp stalls freeze the emit pipeline; req is held off until the row is out.
module rms_norm_forward_backward (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [47:0]  req_tdata,   // x_value, grad_value, acc_value
   input  wire         req_tuser,   // mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // out_value, elem_index, pad
   output logic        rsp_tlast,   // row_last
   output logic        rsp_tuser,   // saturated
   input  wire         csr_wr_en,
   input  wire [15:0]  csr_wr_data
);
   import rmsn_pkg::*;

   state_type st_ff, st_in;
   logic [15:0] eps_ff;
   logic [IdxW-1:0] cnt_ff, cnt_in;
   logic mode_ff, mode_in;
   logic signed [47:0] sq_ff, sq_in, cr_ff, cr_in;
   logic signed [31:0] xx_ff, dx_ff;
   logic mul_vld_ff, mul_first_ff;
   logic acc;
   logic [47:0] m_val;
   logic root_start, root_done;
   logic [30:0] inv;
   logic signed [47:0] g_ff, dot_ff;
   logic signed [63:0] gprod;
   logic [IdxW:0] rd_ptr_ff, rd_ptr_in, out_cnt_ff, out_cnt_in;
   logic [IdxW-1:0] rd_addr;
   logic [15:0] xr, gr, ar;

   // emit pipeline
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IdxW-1:0] i1_ff, i2_ff, i3_ff, i4_ff;
   logic signed [15:0] g2_ff, a2_ff, g3_ff, a3_ff, a4_ff;
   logic signed [47:0] p2_ff;
   logic signed [47:0] y18_ff;
   logic signed [47:0] fwd3_ff;
   logic signed [63:0] t3_full;
   logic signed [47:0] d4_ff, fwd4_ff;
   logic signed [63:0] p5;
   logic signed [47:0] v5;
   logic o_v_ff, o_l_ff, o_s_ff;
   logic [IdxW-1:0] o_i_ff;
   logic [15:0] o_d_ff;
   logic room;

   assign acc = req_tvalid & req_tready;
   assign req_tready = (st_ff == ST_FILL);

   // ---- fill: register products, then accumulate
   always_ff @(posedge clock) begin
      xx_ff <= $signed(req_tdata[15:0]) * $signed(req_tdata[15:0]);
      dx_ff <= $signed(req_tdata[31:16]) * $signed(req_tdata[15:0]);
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= acc;
      end
      mul_first_ff <= (cnt_ff == '0);
   end

   // on a stall keep reading the item held in stage 1
   assign rd_addr = adv ? rd_ptr_ff[IdxW-1:0] : i1_ff;

   rmsn_ram #(.Width(16), .Depth(RowLen)) u_x (
      .clock(clock), .wr_en(acc), .wr_addr(cnt_ff), .wr_data(req_tdata[15:0]),
      .rd_addr(rd_addr), .rd_data(xr));
   rmsn_ram #(.Width(16), .Depth(RowLen)) u_g (
      .clock(clock), .wr_en(acc), .wr_addr(cnt_ff), .wr_data(req_tdata[31:16]),
      .rd_addr(rd_addr), .rd_data(gr));
   rmsn_ram #(.Width(16), .Depth(RowLen)) u_a (
      .clock(clock), .wr_en(acc), .wr_addr(cnt_ff), .wr_data(req_tdata[47:32]),
      .rd_addr(rd_addr), .rd_data(ar));

   always_comb begin
      sq_in = sq_ff; cr_in = cr_ff;
      if (mul_vld_ff) begin
         sq_in = (mul_first_ff ? 48'sd0 : sq_ff) + 48'(xx_ff);
         cr_in = (mul_first_ff ? 48'sd0 : cr_ff) + 48'(dx_ff);
      end
   end

   assign m_val = (sq_ff >>> ShiftLen) + {32'd0, eps_ff};
   // start once the last product has landed in the sums
   assign root_start = (st_ff == ST_DIV) && !mul_vld_ff;

   rmsn_root u_root (
      .clock(clock), .reset(reset), .start(root_start), .m_val(m_val),
      .done(root_done), .inv_q(inv));

   // g stays within 32 signed bits, dot within 29
   assign gprod = 64'($signed(g_ff[31:0])) * 64'($signed({1'b0, inv}));

   // ---- emit pipeline (handshake-frozen)
   assign adv  = !o_v_ff || rsp_tready;
   assign room = adv;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (st_ff == ST_EMIT && room && rd_ptr_ff < (IdxW+1)'(RowLen))
         rd_ptr_in = rd_ptr_ff + 1'b1;
      else if (st_ff != ST_EMIT) rd_ptr_in = '0;
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; mode_in = mode_ff; out_cnt_in = out_cnt_ff;
      case (st_ff)
         ST_FILL: if (acc) begin
            if (cnt_ff == '0) mode_in = req_tuser;
            if (cnt_ff == IdxW'(RowLen-1)) begin
               cnt_in = '0; st_in = ST_DIV;
            end else cnt_in = cnt_ff + 1'b1;
         end
         ST_DIV:  if (!mul_vld_ff) st_in = ST_ROOT;
         ST_ROOT: if (root_done) st_in = ST_DOT;
         ST_DOT:  st_in = ST_EMIT;
         ST_EMIT: begin
            out_cnt_in = out_cnt_ff;
            if (o_v_ff && rsp_tready) out_cnt_in = out_cnt_ff + 1'b1;
            if (o_v_ff && rsp_tready && out_cnt_ff == (IdxW+1)'(RowLen-1)) begin
               st_in = ST_FILL; out_cnt_in = '0;
            end
         end
         default: st_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_FILL; cnt_ff <= '0; mode_ff <= 1'b0; eps_ff <= EpsReset;
         sq_ff <= '0; cr_ff <= '0; rd_ptr_ff <= '0; out_cnt_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; mode_ff <= mode_in;
         if (csr_wr_en) eps_ff <= csr_wr_data;
         sq_ff <= sq_in; cr_ff <= cr_in; rd_ptr_ff <= rd_ptr_in;
         out_cnt_ff <= out_cnt_in;
         if (adv) begin
            v1_ff <= (st_ff == ST_EMIT) && (rd_ptr_ff < (IdxW+1)'(RowLen));
            v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff; o_v_ff <= v4_ff;
         end
      end
      if (st_ff == ST_DIV) g_ff <= cr_ff >>> ShiftLen;
      if (st_ff == ST_DOT) dot_ff <= 48'((gprod + 64'sd131072) >>> 18);
      if (adv) begin
         i1_ff <= rd_ptr_ff[IdxW-1:0];
         // stage 2: x*inv, ram data arrives
         p2_ff <= 48'($signed(xr)) * 48'($signed({1'b0, inv}));
         g2_ff <= $signed(gr); a2_ff <= $signed(ar); i2_ff <= i1_ff;
         // stage 3: rounding both ways
         y18_ff  <= (p2_ff + 48'sd2048) >>> 12;
         fwd3_ff <= (p2_ff + 48'sd131072) >>> 18;
         g3_ff <= g2_ff; a3_ff <= a2_ff; i3_ff <= i2_ff;
         // stage 4: t and diff
         d4_ff  <= 48'(g3_ff) - 48'((t3_full + 64'sd536870912) >>> 30);
         fwd4_ff <= fwd3_ff; a4_ff <= a3_ff; i4_ff <= i3_ff;
         // stage 5: scale, add, saturate
         o_i_ff <= i4_ff;
         o_l_ff <= (i4_ff == IdxW'(RowLen-1));
         if (v5 > 48'sd32767) begin
            o_d_ff <= 16'h7fff; o_s_ff <= 1'b1;
         end else if (v5 < -48'sd32768) begin
            o_d_ff <= 16'h8000; o_s_ff <= 1'b1;
         end else begin
            o_d_ff <= v5[15:0]; o_s_ff <= 1'b0;
         end
      end
   end

   // y18 stays within 23 signed bits and diff within 22
   assign t3_full = 64'($signed(y18_ff[31:0])) * 64'($signed(dot_ff[31:0]));
   assign p5 = 64'($signed(d4_ff[31:0])) * 64'($signed({1'b0, inv}));
   assign v5 = mode_ff ? 48'(a4_ff) + 48'((p5 + 64'sd131072) >>> 18) : fwd4_ff;

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {2'b00, 6'(o_i_ff), o_d_ff};
   assign rsp_tlast  = o_l_ff;
   assign rsp_tuser  = o_s_ff;
endmodule
`default_nettype wire

// File: tb/tb_rms_norm_forward_backward.sv
`timescale 1ns / 1ps
module tb_rms_norm_forward_backward;
   import rmsn_pkg::*;

   typedef struct packed {
      logic        mode;
      logic [15:0] x;
      logic [15:0] dy;
      logic [15:0] dx;
   } elem_t;

   typedef struct packed {
      logic [15:0] value;
      logic [5:0]  index;
      logic        last;
      logic        sat;
   } norm_out_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en = 0;
   logic [15:0] csr_wr_data = '0;

   rms_norm_forward_backward dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   elem_t       pending_elems[$];
   norm_out_t   expected_outs[$];
   int          errors = 0;
   int          send_idle_pct = 6;
   int          recv_idle_pct = 48;
   bit          hold_send = 0;

   // predictor state
   logic signed [15:0] row_x[64], row_dy[64], row_dx[64];
   longint      sq_sum, xd_sum;
   int          fill_count = 0;
   bit          cur_mode = 0;
   logic [15:0] eps_reg = EpsReset;

   function automatic longint shr_floor(longint a, int s);
      return a >>> s;
   endfunction

   function automatic longint shr_round(longint a, int s);
      return (a + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint recip_sqrt(longint unsigned m);
      longint unsigned lim, r, c;
      if (m == 0) m = 1;
      lim = (64'd1 << 60) / m;
      r = 0;
      for (int b = 30; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= lim) r = c;
      end
      return longint'(r);
   endfunction

   task automatic predict_elem(elem_t e);
      longint unsigned m;
      longint inv, g, dot, xv, v, y18, t, diff;
      norm_out_t o;
      if (fill_count == 0) begin
         cur_mode = e.mode;
         sq_sum = 0;
         xd_sum = 0;
      end
      row_x[fill_count] = e.x;
      row_dy[fill_count] = e.dy;
      row_dx[fill_count] = e.dx;
      sq_sum += longint'($signed(e.x)) * longint'($signed(e.x));
      xd_sum += longint'($signed(e.dy)) * longint'($signed(e.x));
      if (fill_count < RowLen - 1) begin
         fill_count++;
         return;
      end
      m = longint'(unsigned'(sq_sum) / RowLen) + eps_reg;
      inv = recip_sqrt(m);
      g = shr_floor(xd_sum, ShiftLen);
      dot = shr_round(g * inv, 18);
      for (int k = 0; k < RowLen; k++) begin
         xv = row_x[k];
         if (!cur_mode) begin
            v = shr_round(xv * inv, 18);
         end else begin
            y18 = shr_round(xv * inv, 12);
            t = shr_round(y18 * dot, 30);
            diff = longint'(row_dy[k]) - t;
            v = longint'(row_dx[k]) + shr_round(diff * inv, 18);
         end
         o.sat = 0;
         if (v > 32767) begin v = 32767; o.sat = 1; end
         if (v < -32768) begin v = -32768; o.sat = 1; end
         o.value = v[15:0];
         o.index = 6'(k);
         o.last = (k == RowLen - 1);
         expected_outs.push_back(o);
      end
      fill_count = 0;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_elem({req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[47:32]});
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_elems.size() > 0 && !(hold_send && expected_outs.size() > 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               elem_t e;
               e = pending_elems.pop_front();
               req_tvalid <= 1;
               req_tuser <= e.mode;
               req_tdata <= {e.dx, e.dy, e.x};
            end else begin
               req_tvalid <= 0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         norm_out_t got, want;
         got = {rsp_tdata[15:0], rsp_tdata[21:16], rsp_tlast, rsp_tuser};
         if (expected_outs.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = expected_outs.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   function automatic logic [15:0] pick16(int kind);
      case (kind)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(16'h0fff)) - 16'h0800;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_row(bit md, int kind);
      elem_t e;
      for (int i = 0; i < RowLen; i++) begin
         e.mode = (i == 0) ? md : 1'($urandom);
         e.x = (kind < 0) ? pick16($urandom_range(4)) : pick16(kind);
         e.dy = pick16($urandom_range(4));
         e.dx = pick16($urandom_range(4));
         pending_elems.push_back(e);
      end
   endtask

   task automatic wait_drained();
      while (pending_elems.size() > 0 || req_tvalid || expected_outs.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_eps(logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      eps_reg = v;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      // zero row with zero epsilon, then extremes
      write_eps(16'd0);
      queue_row(0, 2);
      wait_drained();
      write_eps(16'hffff);
      queue_row(1, 0);
      wait_drained();
      write_eps(EpsReset);
      queue_row(1, 1);
      queue_row(0, 3);
      // sender waits for the row to drain
      hold_send = 1;
      wait_drained();
      hold_send = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 6 : 0;
         if (phase == 1) begin
            wait_drained();
            write_eps($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64)));
         end
         queue_row(1'($urandom), $urandom_range(2) == 0 ? 3 : -1);
      end
      wait_drained();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
